### hdl/masi_pkg.sv
// Package for the average SINR estimator: payload structs, register indexes,
// widths and the dB scale constant. No dependencies.
package masi_pkg;

    typedef struct packed {
        logic signed [15:0] desired_re;
        logic signed [15:0] desired_im;
        logic signed [15:0] intf1_re;
        logic signed [15:0] intf1_im;
        logic signed [15:0] intf2_re;
        logic signed [15:0] intf2_im;
        logic               last_pair;
        logic               last_subcarrier;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sinr_db;
        logic               saturated;
    } t_out_item;

    // Work handed from the front part to the back part at a subcarrier end.
    typedef struct packed {
        logic [47:0] power_sum;
        logic [47:0] corr1_real;
        logic [47:0] corr1_imag;
        logic [47:0] corr2_real;
        logic [47:0] corr2_imag;
        logic        last_subcarrier;
    } t_job;

    localparam logic [2:0] REG_SIGNAL_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTF1_GAIN   = 3'd1;
    localparam logic [2:0] REG_INTF2_GAIN   = 3'd2;
    localparam logic [2:0] REG_TX_ANTENNAS  = 3'd3;
    localparam logic [2:0] REG_INTF1_ENABLE = 3'd4;
    localparam logic [2:0] REG_INTF2_ENABLE = 3'd5;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [31:0] DB_PER_OCTAVE_Q28 = 32'd808071242;
    localparam logic [8:0]  COUNT_MAX = 9'd511;

endpackage

### hdl/mimo_average_sinr_with_interferers_top.sv
// Average SINR estimator top level. The front part accumulates each pair as it
// is transferred and stalls while the job queue is full; each subcarrier end
// runs the back sequencer (a square root per enabled interferer and a 64-step
// divide that a zero denominator skips), and a block end adds the average divide,
// the leading-one search and the 24-step log2 loop. Reset is synchronous, active low, and clears
// all accumulators, the queue and the configuration registers to their defaults.
module mimo_average_sinr_with_interferers_top import masi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_signal_gain, r_intf1_gain, r_intf2_gain;
    logic [2:0]  r_tx_antennas;
    logic        r_intf1_enable, r_intf2_enable;
    logic        q_full, q_valid, push, pop;
    t_job        push_job, q_job;

    // Configuration registers: a write with an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_gain  <= 32'd65536;
            r_intf1_gain   <= 32'd65536;
            r_intf2_gain   <= 32'd65536;
            r_tx_antennas  <= 3'd1;
            r_intf1_enable <= 1'b0;
            r_intf2_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SIGNAL_GAIN:  r_signal_gain  <= i_cfg_data;
                REG_INTF1_GAIN:   r_intf1_gain   <= i_cfg_data;
                REG_INTF2_GAIN:   r_intf2_gain   <= i_cfg_data;
                REG_TX_ANTENNAS:  r_tx_antennas  <= i_cfg_data[2:0];
                REG_INTF1_ENABLE: r_intf1_enable <= i_cfg_data[0];
                REG_INTF2_ENABLE: r_intf2_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front part accumulates each pair as it is transferred.
    masi_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_item,
        .i_intf1_enable(r_intf1_enable), .i_intf2_enable(r_intf2_enable),
        .i_q_full(q_full), .o_stall, .o_push(push), .o_job(push_job)
    );

    // Finished subcarriers wait here while the back part works.
    masi_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(push_job), .i_pop(pop),
        .o_full(q_full), .o_valid(q_valid), .o_job(q_job)
    );

    // The back part computes the ratio and, at block end, the result.
    masi_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .i_job(q_job),
        .i_signal_gain(r_signal_gain), .i_intf1_gain(r_intf1_gain),
        .i_intf2_gain(r_intf2_gain), .i_tx_antennas(r_tx_antennas),
        .i_intf1_enable(r_intf1_enable), .i_intf2_enable(r_intf2_enable),
        .o_pop(pop), .o_valid, .i_stall, .o_item
    );

    // A stalled result must hold its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");
    // The queue is never pushed when full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("job queue overflow");
    // A pop needs a waiting job.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
endmodule

### hdl/masi_front.sv
// Front part: accumulates per-subcarrier power and correlations and pushes a
// job at each subcarrier end. Depends on masi_pkg.
module masi_front import masi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    input  logic        i_intf1_enable,
    input  logic        i_intf2_enable,
    input  logic        i_q_full,
    output logic        o_stall,
    output logic        o_push,
    output t_job        o_job
);
    logic [47:0] r_pw, r_c1r, r_c1i, r_c2r, r_c2i;
    logic [47:0] n_pw, n_c1r, n_c1i, n_c2r, n_c2i;
    logic [32:0] pw;
    logic signed [32:0] t1r, t1i, t2r, t2i;
    logic [48:0] pw_sum;
    logic accept, close;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign close   = i_item.last_pair || i_item.last_subcarrier;

    // Products are small (16x16); the 48-bit adds follow directly.
    always_comb begin
        pw  = 33'(i_item.desired_re * i_item.desired_re)
            + 33'(i_item.desired_im * i_item.desired_im);
        t1r = 33'(i_item.desired_re * i_item.intf1_re)
            + 33'(i_item.desired_im * i_item.intf1_im);
        t1i = 33'(i_item.desired_re * i_item.intf1_im)
            - 33'(i_item.desired_im * i_item.intf1_re);
        t2r = 33'(i_item.desired_re * i_item.intf2_re)
            + 33'(i_item.desired_im * i_item.intf2_im);
        t2i = 33'(i_item.desired_re * i_item.intf2_im)
            - 33'(i_item.desired_im * i_item.intf2_re);
        pw_sum = {1'b0, r_pw} + {16'd0, pw};
        n_pw   = pw_sum[48] ? {48{1'b1}} : pw_sum[47:0];
        n_c1r  = i_intf1_enable ? r_c1r + 48'(t1r) : r_c1r;
        n_c1i  = i_intf1_enable ? r_c1i + 48'(t1i) : r_c1i;
        n_c2r  = i_intf2_enable ? r_c2r + 48'(t2r) : r_c2r;
        n_c2i  = i_intf2_enable ? r_c2i + 48'(t2i) : r_c2i;
    end

    assign o_push = accept && close;
    assign o_job  = '{power_sum: n_pw, corr1_real: n_c1r, corr1_imag: n_c1i,
                      corr2_real: n_c2r, corr2_imag: n_c2i,
                      last_subcarrier: i_item.last_subcarrier};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw <= '0; r_c1r <= '0; r_c1i <= '0; r_c2r <= '0; r_c2i <= '0;
        end else if (accept) begin
            if (close) begin
                r_pw <= '0; r_c1r <= '0; r_c1i <= '0; r_c2r <= '0; r_c2i <= '0;
            end else begin
                r_pw <= n_pw; r_c1r <= n_c1r; r_c1i <= n_c1i;
                r_c2r <= n_c2r; r_c2i <= n_c2i;
            end
        end
    end
endmodule

### hdl/masi_queue.sv
// Short job queue between front and back parts. Depends on masi_pkg.
module masi_queue import masi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);
    t_job r_mem [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'(QUEUE_DEPTH);
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

### hdl/masi_back.sv
// Back part: sequencer that computes magnitudes, the ratio, the running sum
// and, at block end, the log-domain result. Depends on masi_pkg.
module masi_back import masi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    input  logic [31:0] i_signal_gain,
    input  logic [31:0] i_intf1_gain,
    input  logic [31:0] i_intf2_gain,
    input  logic [2:0]  i_tx_antennas,
    input  logic        i_intf1_enable,
    input  logic        i_intf2_enable,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_SQRT = 4'd2;
    localparam logic [3:0] ST_GMUL = 4'd3;
    localparam logic [3:0] ST_NUM  = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_ACC  = 4'd6;
    localparam logic [3:0] ST_AVG  = 4'd7;
    localparam logic [3:0] ST_NORM = 4'd8;
    localparam logic [3:0] ST_LOG  = 4'd9;
    localparam logic [3:0] ST_SCL  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [3:0]  r_st;
    logic        r_k;            // which interferer
    logic [5:0]  r_cnt;
    t_job        r_job;
    logic [63:0] r_sq, r_rem, r_root;
    logic [31:0] r_mag;
    logic [49:0] r_dsum;
    logic [63:0] r_num;
    logic [63:0] r_q;
    logic [64:0] r_prem;
    logic [63:0] r_ratio_sum;
    logic [8:0]  r_count;
    logic [5:0]  r_p;
    logic [31:0] r_m;
    logic [23:0] r_frac;
    logic signed [63:0] r_prod;
    logic        r_ovalid;
    t_out_item   r_oitem;

    logic [47:0] cre, cim, fa, fb;
    logic [31:0] a, b;
    logic [63:0] trial;
    logic [64:0] sh_rem;
    logic [63:0] sum_add;
    logic [64:0] ssum;
    logic [63:0] mm;
    logic [63:0] db_src;
    logic signed [63:0] db;
    logic signed [31:0] log_q24;
    logic [31:0] kgain;
    logic        kena;
    logic        out_free, out_load;

    // Floor to Q.12 and take the magnitude of a 48-bit correlation.
    function automatic logic [31:0] fabs(input logic [47:0] v);
        logic signed [47:0] s;
        s = $signed(v) >>> 16;
        fabs = s[47] ? 32'(-s) : 32'(s);
    endfunction

    assign cre   = r_k ? r_job.corr2_real : r_job.corr1_real;
    assign cim   = r_k ? r_job.corr2_imag : r_job.corr1_imag;
    assign fa    = 48'(fabs(cre));
    assign fb    = 48'(fabs(cim));
    assign a     = fa[31:0];
    assign b     = fb[31:0];
    assign kgain = r_k ? i_intf2_gain : i_intf1_gain;
    assign kena  = r_k ? i_intf2_enable : i_intf1_enable;
    assign trial = r_root + ({63'd0, 1'b1} << {r_cnt, 1'b0});
    assign sh_rem = {r_prem[63:0], r_num[63]};
    assign ssum  = {1'b0, r_ratio_sum} + {1'b0, sum_add};
    assign sum_add = (r_q[63:32] != 0) ? 64'h0000_0000_FFFF_FFFF : r_q;
    assign mm    = 64'(r_m) * 64'(r_m);
    assign log_q24 = $signed({2'b00, r_p, r_frac}) - $signed(32'h1000_0000);
    assign db_src = 64'(r_prod + 64'sh0000_0800_0000_0000);
    assign db    = $signed(db_src) >>> 44;

    // The output register can take a new result when it is empty or draining.
    assign out_free = !(r_ovalid && i_stall);
    assign out_load = out_free && (((r_st == ST_NORM) && (r_q == 0)) || (r_st == ST_OUT));

    assign o_pop   = (r_st == ST_IDLE) && i_job_valid && out_free;
    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ratio_sum <= '0; r_count <= '0;
            r_mag <= 32'hFFFF_FFFF;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_job  <= i_job;
                        r_k    <= 1'b0;
                        r_dsum <= 50'({i_tx_antennas, 12'd0});
                        r_st   <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (kena) begin
                        r_sq   <= 64'(a) * 64'(a);
                        r_rem  <= 64'(b) * 64'(b);
                        r_st   <= ST_SQRT;
                        r_cnt  <= 6'd31;
                        r_root <= '0;
                    end else if (r_k) begin
                        r_st <= ST_NUM;
                    end else begin
                        r_k <= 1'b1;
                    end
                end
                ST_SQRT: begin
                    // One result bit per cycle; the first cycle folds b^2 in when it is nonzero.
                    if (r_cnt == 6'd31 && r_rem != 0) begin
                        r_sq  <= r_sq + r_rem;
                        r_rem <= '0;
                    end else begin
                        if (r_sq >= trial) begin
                            r_sq   <= r_sq - trial;
                            r_root <= (r_root >> 1) + ({63'd0, 1'b1} << {r_cnt, 1'b0});
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        if (r_cnt == 0) r_st <= ST_GMUL;
                        else r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_GMUL: begin
                    r_mag <= r_root[31:0];
                    r_num <= 64'(kgain) * 64'(r_root[31:0]);
                    r_st  <= ST_NUM;
                    r_cnt <= 6'd0;
                end
                ST_NUM: begin
                    // Fold the gain product into the denominator once; an
                    // all-ones magnitude marks a skipped interferer.
                    if (r_mag != 32'hFFFF_FFFF) r_dsum <= r_dsum + 50'(r_num >> 16);
                    r_mag <= 32'hFFFF_FFFF;
                    if (!r_k) begin
                        r_k  <= 1'b1;
                        r_st <= ST_SQ;
                    end else begin
                        r_num  <= 64'(i_signal_gain) * 64'(r_job.power_sum[47:16]);
                        r_prem <= '0;
                        r_q    <= '0;
                        r_cnt  <= 6'd63;
                        r_st   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_dsum == 0) begin
                        r_q  <= 64'h0000_0000_FFFF_FFFF;
                        r_st <= ST_ACC;
                    end else begin
                        r_num <= r_num << 1;
                        if (sh_rem >= {15'd0, r_dsum}) begin
                            r_prem <= sh_rem - {15'd0, r_dsum};
                            r_q    <= {r_q[62:0], 1'b1};
                        end else begin
                            r_prem <= sh_rem;
                            r_q    <= {r_q[62:0], 1'b0};
                        end
                        if (r_cnt == 0) r_st <= ST_ACC;
                        else r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_ACC: begin
                    r_ratio_sum <= ssum[64] ? {64{1'b1}} : ssum[63:0];
                    if (r_count != COUNT_MAX) r_count <= r_count + 9'd1;
                    if (r_job.last_subcarrier) begin
                        r_num  <= ssum[64] ? {64{1'b1}} : ssum[63:0];
                        r_prem <= '0;
                        r_q    <= '0;
                        r_cnt  <= 6'd63;
                        r_st   <= ST_AVG;
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_AVG: begin
                    // Divide the sum by the count, one quotient bit per cycle.
                    r_num <= r_num << 1;
                    if (sh_rem >= {56'd0, r_count}) begin
                        r_prem <= sh_rem - {56'd0, r_count};
                        r_q    <= {r_q[62:0], 1'b1};
                    end else begin
                        r_prem <= sh_rem;
                        r_q    <= {r_q[62:0], 1'b0};
                    end
                    if (r_cnt == 0) begin
                        r_st  <= ST_NORM;
                        r_p   <= 6'd63;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_NORM: begin
                    r_ratio_sum <= '0;
                    r_count     <= '0;
                    if (r_q == 0) begin
                        if (out_free) begin
                            r_oitem  <= '{sinr_db: 16'sh8000, saturated: 1'b1};
                            r_st     <= ST_IDLE;
                        end
                    end else if (r_q[r_p]) begin
                        r_m    <= (r_p >= 6'd31) ? 32'(r_q >> (r_p - 6'd31))
                                                 : 32'(r_q << (6'd31 - r_p));
                        r_frac <= '0;
                        r_cnt  <= 6'd23;
                        r_st   <= ST_LOG;
                    end else begin
                        r_p <= r_p - 6'd1;
                    end
                end
                ST_LOG: begin
                    if (mm[63]) begin
                        r_m    <= mm[63:32];
                        r_frac <= {r_frac[22:0], 1'b1};
                    end else begin
                        r_m    <= mm[62:31];
                        r_frac <= {r_frac[22:0], 1'b0};
                    end
                    if (r_cnt == 0) r_st <= ST_SCL;
                    else r_cnt <= r_cnt - 6'd1;
                end
                ST_SCL: begin
                    r_prod <= log_q24 * $signed(DB_PER_OCTAVE_Q28);
                    r_st   <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        if (db > 64'sd32767)
                            r_oitem <= '{sinr_db: 16'sh7FFF, saturated: 1'b1};
                        else if (db < -64'sd32768)
                            r_oitem <= '{sinr_db: 16'sh8000, saturated: 1'b1};
                        else
                            r_oitem <= '{sinr_db: db[15:0], saturated: 1'b0};
                        r_st     <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
